/* hdl/shc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shc_pkg
// Types and constants shared by the stall hot-spot counter modules.
// ----------------------------------------------------------------------------
package shc_pkg;

	localparam logic [31:0] HASH_MUL  = 32'd2654435761;
	localparam logic [63:0] SYS_LOW_RST  = 64'h0000_0008_0000_0000;
	localparam logic [63:0] SYS_HIGH_RST = 64'h0000_0008_0020_0000;
	localparam logic [5:0]  TOP_LIMIT_RST = 6'd60;
	localparam logic [16:0] COUNT_MAX = 17'd65536;
	localparam logic [63:0] LOW_BYTE_MASK = 64'hffff_ffff_ffff_ff00;
	localparam int QDEPTH = 4;

	localparam logic [1:0] REG_SYS_LOW   = 2'd0;
	localparam logic [1:0] REG_SYS_HIGH  = 2'd1;
	localparam logic [1:0] REG_TOP_LIMIT = 2'd2;

	typedef struct packed {
		logic        op;
		logic        stall_req;
		logic [5:0]  thread;
		logic [63:0] address;
		logic        last_word;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  out_thread;
		logic [63:0] caller;
		logic [63:0] leaf;
		logic [16:0] hit_count;
		logic [15:0] example_seq;
		logic        empty_res;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [63:0] sys_low;
		logic [63:0] sys_high;
		logic [5:0]  top_limit;
	} cfg_t;

	// work handed from front to back
	typedef struct packed {
		logic        rpt;
		logic [63:0] caller;
		logic [55:0] leaf_key;
		logic [5:0]  thread;
		logic [15:0] seq;
	} item_t;

	typedef struct packed {
		logic [63:0] caller;
		logic [55:0] leaf_key;
		logic [5:0]  thread;
		logic [16:0] count;
		logic [15:0] example;
	} slot_t;

	typedef enum logic [3:0] {
		B_IDLE, B_HASH, B_SLOT, B_READ, B_CHECK,
		B_SCAN, B_SDRAIN, B_SDONE, B_EMITLAST, B_CLEAR
	} bstate_t;

endpackage
`default_nettype wire

/* hdl/stall_hotspot_counter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stall_hotspot_counter_unit
// Stall hot-spot counter with a linear-probing table and top-k report.
// ----------------------------------------------------------------------------
// An address word is taken on a cycle with start high and busy low, one per
// cycle while the front queue has room. Each completed stall sample takes
// the table engine through hash, slot, read and check states, with another
// read and check for each extra probe slot (one read port). A report scans
// the whole table once for each emitted entry, then either one more scan
// that finds nothing or, when the entry limit is reached, an emit-last step,
// then a clear sweep. After reset a clear sweep over every slot holds busy
// high. Results appear on result for one cycle marked by result_valid and
// cannot be held off. SLOTS must be a power of two.
module stall_hotspot_counter_unit
	import shc_pkg::*;
#(
	parameter int SLOTS   = 4096,
	parameter int FRAMES  = 10,
	parameter int TOP_MAX = 60
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire cmd_t        cmd,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output logic             result_valid,
	output res_t             result
);

	cfg_t  cfg_q;
	logic  accept, push, pop, empty, full, init_busy;
	item_t push_item, head;

	assign busy   = full || init_busy;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sys_low   <= SYS_LOW_RST;
			cfg_q.sys_high  <= SYS_HIGH_RST;
			cfg_q.top_limit <= TOP_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYS_LOW:   cfg_q.sys_low   <= cfg_data;
				REG_SYS_HIGH:  cfg_q.sys_high  <= cfg_data;
				REG_TOP_LIMIT: cfg_q.top_limit <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	shc_front #(.FRAMES(FRAMES)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .cmd(cmd), .cfg(cfg_q),
		.push(push), .item(push_item)
	);

	shc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .head(head), .empty(empty), .full(full)
	);

	shc_back #(.SLOTS(SLOTS), .TOP_MAX(TOP_MAX)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .empty(empty),
		.top_limit(cfg_q.top_limit), .pop(pop), .init_busy(init_busy),
		.result_valid(result_valid), .result(result)
	);

endmodule
`default_nettype wire

/* hdl/shc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shc_front
// Assembles address words into samples and classifies them into table work.
// ----------------------------------------------------------------------------
module shc_front
	import shc_pkg::*;
#(
	parameter int FRAMES = 10
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire cmd_t  cmd,
	input  wire cfg_t  cfg,
	output logic       push,
	output item_t      item
);

	localparam int PW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [63:0] first_q, pick_q;
	logic        found_q;
	logic [PW-1:0] pos_q;
	logic [15:0] seq_q;

	logic [63:0] fw, pick;
	logic        found, in_sys, done;

	assign in_sys = (cmd.address >= cfg.sys_low) && (cmd.address < cfg.sys_high);

	always_comb begin
		if (pos_q == '0) begin
			fw    = cmd.address;
			found = !in_sys;
			pick  = cmd.address;
		end else if (!found_q && cmd.address != 64'd0 && !in_sys) begin
			fw    = first_q;
			found = 1'b1;
			pick  = cmd.address;
		end else begin
			fw    = first_q;
			found = found_q;
			pick  = pick_q;
		end
		done = cmd.last_word || (int'(pos_q) + 1 >= FRAMES);
	end

	always_comb begin
		item.rpt      = cmd.op;
		item.caller   = found ? pick : fw;
		item.leaf_key = fw[63:8];
		item.thread   = cmd.thread;
		item.seq      = seq_q;
		push = accept && (cmd.op || (done && cmd.stall_req));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			pick_q  <= '0;
			found_q <= 1'b0;
			pos_q   <= '0;
			seq_q   <= '0;
		end else if (accept && !cmd.op) begin
			first_q <= fw;
			pick_q  <= pick;
			if (done) begin
				pos_q   <= '0;
				found_q <= 1'b0;
				seq_q   <= seq_q + 16'd1;
			end else begin
				pos_q   <= pos_q + PW'(1);
				found_q <= found;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/shc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shc_queue
// Short queue between sample front and table back.
// ----------------------------------------------------------------------------
module shc_queue
	import shc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      head,
	output logic       empty,
	output logic       full
);

	localparam int QW = $clog2(QDEPTH);

	item_t          ent_q [QDEPTH];
	logic [QW-1:0]  wr_q, rd_q;
	logic [QW:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QW+1)'(QDEPTH));
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QW'(1);
			if (pop)  rd_q <= rd_q + QW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (QW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* hdl/shc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shc_back
// Hash table engine: probing insert, top-k report scans and clear sweeps.
// ----------------------------------------------------------------------------
module shc_back
	import shc_pkg::*;
#(
	parameter int SLOTS   = 4096,
	parameter int TOP_MAX = 60
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t head,
	input  wire logic  empty,
	input  wire logic  [5:0] top_limit,
	output logic       pop,
	output logic       init_busy,
	output logic       result_valid,
	output res_t       result
);

	localparam int AW = $clog2(SLOTS);
	localparam int KW = $clog2(TOP_MAX + 1);

	slot_t mem [SLOTS];
	slot_t rd_q;

	bstate_t state_q, state_d;
	item_t   cur_q;
	logic [31:0] prod_q;
	logic [AW-1:0] slot_q, probes_q, scan_q, clr_q, cmp_slot_q, best_slot_q;
	logic        cmp_vld_q;
	slot_t       best_q, pend_q;
	logic        pend_vld_q;
	logic [KW-1:0] k_q;
	logic        init_q;
	logic        res_vld_q;
	res_t        res_q;

	logic        mem_we;
	logic [AW-1:0] waddr, raddr;
	slot_t       wdata;
	logic        hit, found, k_full;
	int          lim;
	logic        res_vld_d;
	res_t        res_d;

	assign init_busy    = init_q;
	assign result_valid = res_vld_q;
	assign result       = res_q;

	always_comb begin
		if (top_limit == 6'd0) lim = 1;
		else if (int'(top_limit) > TOP_MAX) lim = TOP_MAX;
		else lim = int'(top_limit);
		k_full = (int'(k_q) + 1 >= lim);
		found  = (best_q.count != 17'd0);
		hit = (rd_q.count == 17'd0) ||
			(rd_q.caller == cur_q.caller && rd_q.leaf_key == cur_q.leaf_key &&
			 rd_q.thread == cur_q.thread);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:     if (!empty) state_d = head.rpt ? B_SCAN : B_HASH;
			B_HASH:     state_d = B_SLOT;
			B_SLOT:     state_d = B_READ;
			B_READ:     state_d = B_CHECK;
			B_CHECK: begin
				if (hit || probes_q == AW'(SLOTS - 1)) state_d = B_IDLE;
				else state_d = B_READ;
			end
			B_SCAN:     if (scan_q == AW'(SLOTS - 1)) state_d = B_SDRAIN;
			B_SDRAIN:   state_d = B_SDONE;
			B_SDONE: begin
				if (!found) state_d = B_CLEAR;
				else if (k_full) state_d = B_EMITLAST;
				else state_d = B_SCAN;
			end
			B_EMITLAST: state_d = B_CLEAR;
			B_CLEAR:    if (clr_q == AW'(SLOTS - 1)) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	// memory port and queue control
	always_comb begin
		pop    = 1'b0;
		mem_we = 1'b0;
		waddr  = slot_q;
		raddr  = slot_q;
		wdata  = '0;
		unique case (state_q)
			B_IDLE: pop = !empty;
			B_CHECK: begin
				if (hit) begin
					mem_we = 1'b1;
					wdata.caller   = cur_q.caller;
					wdata.leaf_key = cur_q.leaf_key;
					wdata.thread   = cur_q.thread;
					wdata.example  = cur_q.seq;
					wdata.count    = (rd_q.count < COUNT_MAX) ?
						rd_q.count + 17'd1 : rd_q.count;
				end
			end
			B_SCAN: raddr = scan_q;
			B_SDONE: begin
				if (found) begin
					mem_we = 1'b1;
					waddr  = best_slot_q;
					wdata  = best_q;
					wdata.count = 17'd0;
				end
			end
			B_CLEAR: begin
				mem_we = 1'b1;
				waddr  = clr_q;
			end
			default: ;
		endcase
	end

	// result beat: the pending entry goes out once the next scan has decided, or in the emit-last step at the entry limit
	always_comb begin
		res_vld_d = 1'b0;
		res_d     = res_q;
		if (state_q == B_SDONE) begin
			res_vld_d = found ? pend_vld_q : 1'b1;
			res_d     = '0;
			if (pend_vld_q) begin
				res_d.out_thread  = pend_q.thread;
				res_d.caller      = pend_q.caller;
				res_d.leaf        = {pend_q.leaf_key, 8'h00};
				res_d.hit_count   = pend_q.count;
				res_d.example_seq = pend_q.example;
			end
			res_d.last      = !found;
			res_d.empty_res = !found && !pend_vld_q;
		end else if (state_q == B_EMITLAST) begin
			res_vld_d         = 1'b1;
			res_d             = '0;
			res_d.out_thread  = pend_q.thread;
			res_d.caller      = pend_q.caller;
			res_d.leaf        = {pend_q.leaf_key, 8'h00};
			res_d.hit_count   = pend_q.count;
			res_d.example_seq = pend_q.example;
			res_d.last        = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !empty) cur_q <= head;
		prod_q <= (cur_q.caller[35:4] ^ cur_q.leaf_key[31:0]) * HASH_MUL;
		cmp_slot_q <= scan_q;
		if (state_q == B_SCAN && state_d == B_SCAN) scan_q <= scan_q + AW'(1);
		else if (state_q == B_IDLE || state_q == B_SDONE) scan_q <= '0;
		if (state_q == B_IDLE || state_q == B_SDONE) begin
			best_q.count <= 17'd0;
		end else if (cmp_vld_q && rd_q.count > best_q.count) begin
			best_q      <= rd_q;
			best_slot_q <= cmp_slot_q;
		end
		if (state_q == B_SDONE && found) pend_q <= best_q;
		if (state_q == B_SLOT) begin
			slot_q   <= prod_q[AW-1:0];
			probes_q <= '0;
		end else if (state_q == B_CHECK) begin
			slot_q   <= slot_q + AW'(1);
			probes_q <= probes_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			init_q     <= 1'b1;
			clr_q      <= '0;
			cmp_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
			k_q        <= '0;
			res_vld_q  <= 1'b0;
			res_q      <= '0;
		end else begin
			state_q   <= state_d;
			cmp_vld_q <= (state_q == B_SCAN);
			res_vld_q <= res_vld_d;
			res_q     <= res_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(SLOTS - 1)) init_q <= 1'b0;
			end
			if (state_q == B_IDLE) begin
				k_q        <= '0;
				pend_vld_q <= 1'b0;
			end
			if (state_q == B_SDONE && found) begin
				pend_vld_q <= 1'b1;
				k_q        <= k_q + KW'(1);
			end
		end
	end

	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> ($past(state_q) == B_SDONE || $past(state_q) == B_EMITLAST))
		else $error("result strobe outside report decision");
	a_idle_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_IDLE |-> !mem_we)
		else $error("table write while idle");
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.empty_res |-> res_q.last && res_q.hit_count == 17'd0)
		else $error("empty report not final");
	a_no_pop_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !pop)
		else $error("queue pop during initial clear");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stall hot-spot counter testbench
// Drives address words and report commands into the counter, keeps its own
// hash table to predict each report, and compares every reported entry.
// ----------------------------------------------------------------------------
module testbench;
	import shc_pkg::*;

	localparam int SLOTS     = 4096;
	localparam int FRAMES    = 10;
	localparam int TOP_MAX   = 60;
	localparam int WDOG_MAX  = 2000000;

	class hotspot_board;
		logic [63:0] sys_low, sys_high;
		logic [5:0]  top_limit;
		logic [63:0] tab_caller [SLOTS];
		logic [55:0] tab_leaf [SLOTS];
		logic [5:0]  tab_thread [SLOTS];
		logic [16:0] tab_count [SLOTS];
		logic [15:0] tab_example [SLOTS];
		logic [63:0] first_word, caller_pick;
		bit          caller_found;
		int          word_pos;
		logic [15:0] seq;
		res_t        pending_reports[$];
		int          errors;
		int          results_seen;
		int          hot_entries;

		function new();
			sys_low = SYS_LOW_RST;
			sys_high = SYS_HIGH_RST;
			top_limit = TOP_LIMIT_RST;
			for (int i = 0; i < SLOTS; i++) begin
				tab_count[i] = '0;
				tab_caller[i] = '0;
				tab_leaf[i] = '0;
				tab_thread[i] = '0;
				tab_example[i] = '0;
			end
			first_word = '0;
			caller_pick = '0;
			caller_found = 0;
			word_pos = 0;
			seq = '0;
			errors = 0;
			results_seen = 0;
			hot_entries = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [63:0] val);
			case (idx)
				REG_SYS_LOW: sys_low = val;
				REG_SYS_HIGH: sys_high = val;
				REG_TOP_LIMIT: top_limit = val[5:0];
				default: ;
			endcase
		endfunction

		function bit in_sys(logic [63:0] a);
			return a >= sys_low && a < sys_high;
		endfunction

		function void tally(logic [63:0] caller, logic [63:0] leaf, logic [5:0] thr);
			logic [63:0] mixed;
			logic [55:0] key;
			int slot;
			key = leaf[63:8];
			mixed = ((caller >> 4) ^ (leaf >> 8)) * 64'(HASH_MUL);
			slot = int'(mixed[31:0] % SLOTS);
			for (int p = 0; p < SLOTS; p++) begin
				if (tab_count[slot] == 0 || (tab_caller[slot] == caller &&
						tab_leaf[slot] == key && tab_thread[slot] == thr)) begin
					tab_caller[slot] = caller;
					tab_leaf[slot] = key;
					tab_thread[slot] = thr;
					tab_example[slot] = seq;
					if (tab_count[slot] < COUNT_MAX)
						tab_count[slot]++;
					return;
				end
				slot = (slot + 1) % SLOTS;
			end
		endfunction

		function void rank_and_clear();
			int limit, n, best;
			res_t r;
			limit = (top_limit == 0) ? 1 : int'(top_limit);
			if (limit > TOP_MAX)
				limit = TOP_MAX;
			n = 0;
			for (int k = 0; k < limit; k++) begin
				best = SLOTS;
				for (int s = 0; s < SLOTS; s++)
					if (tab_count[s] != 0 && (best == SLOTS || tab_count[s] > tab_count[best]))
						best = s;
				if (best == SLOTS)
					break;
				r = '0;
				r.out_thread = tab_thread[best];
				r.caller = tab_caller[best];
				r.leaf = {tab_leaf[best], 8'h00};
				r.hit_count = tab_count[best];
				r.example_seq = tab_example[best];
				tab_count[best] = '0;
				pending_reports.push_back(r);
				n++;
			end
			hot_entries += n;
			if (n == 0) begin
				r = '0;
				r.empty_res = 1;
				r.last = 1;
				pending_reports.push_back(r);
			end else begin
				pending_reports[$].last = 1;
			end
			for (int s = 0; s < SLOTS; s++)
				tab_count[s] = '0;
		endfunction

		function void note_cmd(cmd_t c);
			bit done;
			if (c.op) begin
				rank_and_clear();
				return;
			end
			if (word_pos == 0) begin
				first_word = c.address;
				caller_found = !in_sys(c.address);
				caller_pick = c.address;
			end else if (!caller_found && c.address != 0 && !in_sys(c.address)) begin
				caller_found = 1;
				caller_pick = c.address;
			end
			done = c.last_word || word_pos + 1 >= FRAMES;
			if (!done) begin
				word_pos++;
				return;
			end
			if (c.stall_req)
				tally(caller_found ? caller_pick : first_word,
					first_word & LOW_BYTE_MASK, c.thread);
			seq++;
			word_pos = 0;
			caller_found = 0;
		endfunction

		function void check_result(res_t got);
			res_t want;
			results_seen++;
			if (pending_reports.size() == 0) begin
				$error("unexpected report beat %p", got);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			if (got.out_thread !== want.out_thread) begin
				$error("out_thread exp %0d got %0d", want.out_thread, got.out_thread);
				errors++;
			end
			if (got.caller !== want.caller) begin
				$error("caller exp %h got %h", want.caller, got.caller);
				errors++;
			end
			if (got.leaf !== want.leaf) begin
				$error("leaf exp %h got %h", want.leaf, got.leaf);
				errors++;
			end
			if (got.hit_count !== want.hit_count) begin
				$error("hit_count exp %0d got %0d", want.hit_count, got.hit_count);
				errors++;
			end
			if (got.example_seq !== want.example_seq) begin
				$error("example_seq exp %0d got %0d", want.example_seq, got.example_seq);
				errors++;
			end
			if (got.empty_res !== want.empty_res) begin
				$error("empty_res exp %0b got %0b", want.empty_res, got.empty_res);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last exp %0b got %0b", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        result_valid;
	res_t        result;

	hotspot_board board;
	int          idle_cycles;
	int          items_sent;

	stall_hotspot_counter_unit #(.SLOTS(SLOTS), .FRAMES(FRAMES), .TOP_MAX(TOP_MAX)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		board = new();
		idle_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				board.check_result(result);
			if ((start && !busy) || result_valid)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_MAX) begin
				$display("watchdog expired, %0d reports outstanding",
					board.pending_reports.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	task automatic send(cmd_t c);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_cmd(c);
		items_sent++;
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending_reports.size() != 0)
			@(posedge clk);
		// let the clear sweep finish
		repeat (SLOTS + 64) @(posedge clk);
	endtask

	function automatic cmd_t word(logic [63:0] a, bit lw, bit st, logic [5:0] thr);
		cmd_t c;
		c.op = 1'b0;
		c.stall_req = st;
		c.thread = thr;
		c.address = a;
		c.last_word = lw;
		return c;
	endfunction

	function automatic cmd_t report_cmd();
		cmd_t c;
		c = '0;
		c.op = 1'b1;
		c.stall_req = $urandom_range(0, 1);
		c.thread = $urandom_range(0, 63);
		c.address = {$urandom, $urandom};
		c.last_word = $urandom_range(0, 1);
		return c;
	endfunction

	// pick an address from a small pool so samples collide and group
	function automatic logic [63:0] pick_addr(bit fresh);
		case ($urandom_range(0, 5))
			0: return board.sys_low + $urandom_range(0, 255);
			1: return 64'h0;
			2: return fresh ? {$urandom, $urandom} : 64'hffff_ffff_ffff_ffff;
			default: return 64'h40_0000 + 64'($urandom_range(0, 7)) * 64'h1230;
		endcase
	endfunction

	task automatic send_sample(int words, bit st, logic [5:0] thr, bit noisy);
		cmd_t c;
		for (int w = 0; w < words; w++) begin
			c = word(pick_addr(noisy), w == words - 1, $urandom_range(0, 1),
				6'($urandom_range(0, 63)));
			if (w == words - 1) begin
				c.stall_req = st;
				c.thread = thr;
			end
			send(c);
			if ($urandom_range(0, 3) == 0)
				pause($urandom_range(1, 4));
		end
	endtask

	initial begin
		int burst;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = REG_SYS_LOW;
		cfg_data = '0;
		items_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty report, extremes, frame cap, report mid-sample
		send(report_cmd());
		send(word(64'hffff_ffff_ffff_ffff, 1, 1, 6'd63));
		send(word(64'h0, 1, 1, 6'd0));
		send(word(SYS_LOW_RST, 0, 0, 6'd5));
		send(word(64'h0, 0, 0, 6'd5));
		send(word(64'h1234_5678, 1, 1, 6'd5));
		send(word(SYS_LOW_RST + 8, 0, 1, 6'd9));
		send(word(SYS_HIGH_RST - 1, 1, 1, 6'd9));
		send(word(64'h77, 0, 0, 6'd1));
		send(report_cmd());
		for (int w = 1; w < FRAMES + 1; w++)
			send(word(64'h1000 + w, 0, 1, 6'd2));
		send(word(64'h1001, 1, 0, 6'd2));
		drain();

		// same key repeated plus a thread split on one slot
		for (int i = 0; i < 4; i++)
			send(word(64'h5555_0011, 1, 1, 6'(i & 1)));
		drain();
		write_reg(REG_TOP_LIMIT, 6'd1);
		send(report_cmd());
		drain();
		write_reg(REG_TOP_LIMIT, 6'd0);
		send(word(64'h9900, 1, 1, 6'd3));
		send(word(64'h9a00, 1, 1, 6'd3));
		send(report_cmd());
		drain();

		// random phases through several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_SYS_LOW, 64'h0);
					write_reg(REG_SYS_HIGH, 64'hffff_ffff_ffff_ffff);
					write_reg(REG_TOP_LIMIT, 6'd63);
				end
				1: begin
					write_reg(REG_SYS_LOW, 64'h40_0000);
					write_reg(REG_SYS_HIGH, 64'h40_5000);
					write_reg(REG_TOP_LIMIT, 6'd3);
				end
				2: write_reg(REG_TOP_LIMIT, 6'd60);
				3: begin
					write_reg(REG_SYS_LOW, SYS_LOW_RST);
					write_reg(REG_SYS_HIGH, SYS_HIGH_RST);
				end
				4: write_reg(REG_TOP_LIMIT, 6'($urandom_range(1, 63)));
				default: write_reg(REG_TOP_LIMIT, 6'd2);
			endcase
			while (items_sent < 60 + (ph + 1) * 45) begin
				burst = $urandom_range(1, 6);
				for (int b = 0; b < burst; b++) begin
					if ($urandom_range(0, 19) == 0)
						send(report_cmd());
					else
						send_sample($urandom_range(1, FRAMES + 2), $urandom_range(0, 4) != 0,
							6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : 1),
							$urandom_range(0, 9) == 0);
				end
				if ($urandom_range(0, 2) != 0)
					pause($urandom_range(1, 12));
			end
			send(report_cmd());
			drain();
		end

		$display("%0d command beats, %0d report beats checked, %0d hot-spot entries",
			items_sent, board.results_seen, board.hot_entries);
		if (board.errors == 0 && board.pending_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
